// ===== rtl/psrf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrf_pkg: shared types and constants of the printable string run finder
// Input and result words, the scan-to-queue result bundle and the
// printable range limits.
// ----------------------------------------------------------------------------
package psrf_pkg;

  // Run kinds reported in a result word
  localparam logic KIND_ASCII = 1'b0;
  localparam logic KIND_WIDE  = 1'b1;

  // Minimum length used when the register holds zero
  localparam logic [7:0] DEFAULT_MIN_LEN = 8'd4;

  // Printable range, shared by bytes and 16-bit units
  localparam logic [15:0] PRINT_LO = 16'h0020;
  localparam logic [15:0] PRINT_HI = 16'h007E;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] next_byte;
    logic       has_next;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] start_offset;
    logic [31:0] end_offset;
    logic        last;
  } out_word_t;

  // Results of one scanned byte: zero, one or two words, word0 first
  typedef struct packed {
    logic [1:0] count;
    out_word_t  word0;
    out_word_t  word1;
  } scan_result_t;

endpackage

// ===== rtl/printable_string_run_finder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// printable_string_run_finder: ASCII and UTF-16LE printable run finder
// Scans one byte per word and reports the runs that end at it.
// ----------------------------------------------------------------------------
// One input word is taken every cycle unless input stalls: each word is
// registered in the input stage, scanned there and its zero, one or two
// result words go to a four-entry result queue. The single result port
// drains one word per cycle while out_ready is high, so the long-run rate
// is one byte per cycle as long as results average no more than one per
// byte; a byte that closes both an ASCII and a wide run gives two results.
// Input stalls only when the queue has fewer than two free entries. Write
// min_length only while idle (unenforced); zero selects four characters.
module printable_string_run_finder #(
  parameter int OFFSET_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  psrf_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output psrf_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);
  import psrf_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QPTR   = $clog2(QDEPTH);
  localparam int QCNT   = $clog2(QDEPTH + 1);

  logic [7:0]     min_length;
  logic           stage_valid;
  in_word_t       stage_word;
  logic           fire;
  scan_result_t   res;

  out_word_t      queue [QDEPTH];
  logic [QPTR-1:0] wr_ptr;
  logic [QPTR-1:0] rd_ptr;
  logic [QCNT-1:0] count;
  logic [QCNT-1:0] count_next;
  logic            pop;
  logic [1:0]      push_n;

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      min_length <= cfg_data;
    end
  end

  // Input stage: scan fires when the queue can take two words
  assign fire     = stage_valid && (count <= QCNT'(QDEPTH - 2));
  assign in_ready = !stage_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_word <= in_data;
    end
  end

  psrf_scan #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .advance    (fire),
    .item       (stage_word),
    .min_length (min_length),
    .result     (res)
  );

  // Result queue
  assign push_n     = fire ? res.count : 2'd0;
  assign pop        = out_valid && out_ready;
  assign count_next = count + QCNT'(push_n) - QCNT'(pop);
  assign out_valid  = (count != '0);
  assign out_data   = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR'(push_n);
      rd_ptr <= rd_ptr + QPTR'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= res.word0;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + QPTR'(1)] <= res.word1;
    end
  end

`ifndef SYNTH
  // Queue never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT'(QDEPTH))
    else $error("result queue overflow");

  // A stalled input always means a word is waiting in the stage
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> stage_valid)
    else $error("input stalled with empty stage");

  // Two results from one byte: only the second carries last
  a_last_order: assert property (@(posedge clk) disable iff (rst)
    (fire && res.count == 2'd2) |-> (!res.word0.last && res.word1.last))
    else $error("last flag misplaced on paired results");

  // A scanned word never pushes more than the queue had room for
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    fire |=> (count <= QCNT'(QDEPTH)))
    else $error("push without room");
`endif

endmodule

// ===== rtl/psrf_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrf_scan: run tracking for one byte
// Holds the byte position and the ASCII, even-wide and odd-wide runs,
// decides which runs end at the current byte and updates state on advance.
// ----------------------------------------------------------------------------
module psrf_scan #(
  parameter int OFFSET_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  psrf_pkg::in_word_t      item,
  input  logic [7:0]              min_length,
  output psrf_pkg::scan_result_t  result
);
  import psrf_pkg::*;

  logic [OFFSET_BITS-1:0] position;
  logic                   narrow_active;
  logic [OFFSET_BITS-1:0] narrow_start;
  logic                   even_active;
  logic [OFFSET_BITS-1:0] even_start;
  logic                   odd_active;
  logic [OFFSET_BITS-1:0] odd_start;

  logic [7:0]             min_len;
  logic [15:0]            unit;
  logic                   narrow_ok;
  logic                   wide_ok;
  logic                   sel_active;
  logic [OFFSET_BITS-1:0] sel_start;
  logic [OFFSET_BITS-1:0] narrow_len;
  logic [OFFSET_BITS-1:0] wide_len;
  logic                   narrow_hit;
  logic                   wide_hit;
  out_word_t              narrow_word;
  out_word_t              wide_word;

  // Character classes
  assign min_len   = (min_length == 8'd0) ? DEFAULT_MIN_LEN : min_length;
  assign unit      = item.has_next ? {item.next_byte, item.data_byte} : 16'd0;
  assign narrow_ok = ({8'd0, item.data_byte} >= PRINT_LO) &&
                     ({8'd0, item.data_byte} <= PRINT_HI);
  assign wide_ok   = (unit >= PRINT_LO) && (unit <= PRINT_HI);

  // Wide run of the current parity
  assign sel_active = position[0] ? odd_active : even_active;
  assign sel_start  = position[0] ? odd_start  : even_start;

  // Run lengths in characters, modulo the offset width
  assign narrow_len = position - narrow_start;
  assign wide_len   = (position - sel_start) >> 1;

  assign narrow_hit = !narrow_ok && narrow_active &&
                      (narrow_len >= OFFSET_BITS'(min_len));
  assign wide_hit   = !wide_ok && sel_active &&
                      (wide_len >= OFFSET_BITS'(min_len));

  // Result words; ASCII first when both runs end here
  always_comb begin
    narrow_word.kind         = KIND_ASCII;
    narrow_word.start_offset = 32'(narrow_start);
    narrow_word.end_offset   = 32'(position);
    narrow_word.last         = 1'b0;
    wide_word.kind           = KIND_WIDE;
    wide_word.start_offset   = 32'(sel_start);
    wide_word.end_offset     = 32'(position);
    wide_word.last           = 1'b1;

    result.count      = {1'b0, narrow_hit} + {1'b0, wide_hit};
    result.word0      = narrow_hit ? narrow_word : wide_word;
    result.word0.last = !(narrow_hit && wide_hit);
    result.word1      = wide_word;
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      narrow_active <= 1'b0;
      narrow_start  <= '0;
      even_active   <= 1'b0;
      even_start    <= '0;
      odd_active    <= 1'b0;
      odd_start     <= '0;
    end else if (advance) begin
      position <= position + OFFSET_BITS'(1);
      if (narrow_ok) begin
        if (!narrow_active) begin
          narrow_active <= 1'b1;
          narrow_start  <= position;
        end
      end else begin
        narrow_active <= 1'b0;
      end
      if (position[0]) begin
        if (wide_ok) begin
          if (!odd_active) begin
            odd_active <= 1'b1;
            odd_start  <= position;
          end
        end else begin
          odd_active <= 1'b0;
        end
      end else begin
        if (wide_ok) begin
          if (!even_active) begin
            even_active <= 1'b1;
            even_start  <= position;
          end
        end else begin
          even_active <= 1'b0;
        end
      end
    end
  end

endmodule
